// File: sv/u8s_pkg.sv
// Package: request/result types, sizes and byte constants for the UTF-8 sanitizer.
package u8s_pkg;

	localparam int HOLD_DEPTH = 5;
	localparam int HOLD_CNT_W = 3;
	localparam int HOLD_IDX_W = 3;
	localparam int MAX_RES    = 4;
	localparam int RES_DEPTH  = 8;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);
	localparam int EMIT_W     = 3;

	localparam logic [7:0] SUR_LEAD = 8'hED;
	localparam logic [3:0] SUR_HI_NIB = 4'hA;
	localparam logic [3:0] SUR_LO_NIB = 4'hB;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       terminator;
	} u8s_req_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       is_end;
	} u8s_res_t;

	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] n;
		if (b[7] == 1'b0) begin
			n = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			n = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			n = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			n = 3'd4;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

// File: sv/utf8_sanitize_cesu8_repair.sv
// UTF-8 sanitizer with CESU-8 surrogate pair repair (top level).
// A request is registered in the input stage, decoded from there once the result queue has
// room, and its results are written into the result queue, whose head drives res.
// Throughput: one request per cycle while the 8-entry result queue has 4 entries free;
// 0 to 4 results per request leave it one per cycle while res_ready is high.
// Reset clears the lookahead count, the queue pointers and the input stage.
module utf8_sanitize_cesu8_repair (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  u8s_pkg::u8s_req_t req,
	output logic              res_valid,
	input  logic              res_ready,
	output u8s_pkg::u8s_res_t res
);
	import u8s_pkg::*;

	logic                  valid_s1;
	u8s_req_t              req_s1;
	logic [7:0]            held_q [HOLD_DEPTH];
	logic [HOLD_CNT_W-1:0] held_cnt_q;
	u8s_res_t              fifo_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]  wr_ptr_q;
	logic [RES_PTR_W-1:0]  rd_ptr_q;
	logic [RES_CNT_W-1:0]  fifo_cnt_q;

	logic                  proc;
	logic                  pop;
	logic [7:0]            b;
	logic                  b_cont;
	logic [2:0]            lead_n;
	logic [2:0]            b_n;
	logic                  sur;
	logic                  single_f;
	logic [HOLD_CNT_W-1:0] cnt_nxt;
	logic                  wr_en;
	logic [HOLD_IDX_W-1:0] wr_idx;
	logic [EMIT_W-1:0]     emit_n;
	u8s_res_t              emit [MAX_RES];
	logic [9:0]            hh;
	logic [9:0]            ll;
	logic [20:0]           cp;

	assign proc      = valid_s1 && (fifo_cnt_q <= RES_CNT_W'(RES_DEPTH - MAX_RES));
	assign req_ready = !valid_s1 || proc;
	assign res_valid = fifo_cnt_q != '0;
	assign res       = fifo_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	assign b      = req_s1.byte_in;
	assign b_cont = is_cont(b);
	assign lead_n = seq_len(held_q[0]);
	assign b_n    = seq_len(b);
	assign sur    = (held_cnt_q >= HOLD_CNT_W'(3)) && (held_q[0] == SUR_LEAD)
		&& (held_q[1][7:4] == SUR_HI_NIB);

	assign hh = {held_q[1][3:0], held_q[2][5:0]};
	assign ll = {held_q[4][3:0], b[5:0]};
	assign cp = SUPP_BASE + {1'b0, hh, ll};

	always_comb begin
		cnt_nxt  = held_cnt_q;
		wr_en    = 1'b0;
		wr_idx   = '0;
		emit_n   = '0;
		single_f = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			emit[i] = '0;
		end
		if (req_s1.terminator) begin
			cnt_nxt = '0;
			emit_n  = EMIT_W'(1);
			emit[0] = '{byte_out: 8'h00, is_end: 1'b1};
		end else if (held_cnt_q == '0) begin
			single_f = 1'b1;
		end else if (!sur) begin
			if (!b_cont) begin
				single_f = 1'b1;
			end else if ((held_cnt_q + HOLD_CNT_W'(1)) < lead_n) begin
				wr_en   = 1'b1;
				wr_idx  = held_cnt_q;
				cnt_nxt = held_cnt_q + HOLD_CNT_W'(1);
			end else if (lead_n == 3'd3 && held_q[0] == SUR_LEAD && held_q[1][5]) begin
				// encoded surrogate: low half alone is dropped, high half waits
				if (held_q[1][4]) begin
					cnt_nxt = '0;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = held_cnt_q;
					cnt_nxt = held_cnt_q + HOLD_CNT_W'(1);
				end
			end else begin
				cnt_nxt = '0;
				emit_n  = lead_n;
				emit[0] = '{byte_out: held_q[0], is_end: 1'b0};
				emit[1] = '{byte_out: (lead_n == 3'd2) ? b : held_q[1], is_end: 1'b0};
				emit[2] = '{byte_out: (lead_n == 3'd3) ? b : held_q[2], is_end: 1'b0};
				emit[3] = '{byte_out: b, is_end: 1'b0};
			end
		end else begin
			case (held_cnt_q)
				HOLD_CNT_W'(3): begin
					if (b == SUR_LEAD) begin
						wr_en   = 1'b1;
						wr_idx  = HOLD_IDX_W'(3);
						cnt_nxt = HOLD_CNT_W'(4);
					end else begin
						single_f = 1'b1;
					end
				end
				HOLD_CNT_W'(4): begin
					if (b[7:4] == SUR_LO_NIB) begin
						wr_en   = 1'b1;
						wr_idx  = HOLD_IDX_W'(4);
						cnt_nxt = HOLD_CNT_W'(5);
					end else if (b_cont) begin
						// high surrogate dropped, ED plus this byte restart a sequence
						wr_en   = 1'b1;
						wr_idx  = HOLD_IDX_W'(1);
						cnt_nxt = HOLD_CNT_W'(2);
					end else begin
						single_f = 1'b1;
					end
				end
				default: begin
					if (b_cont) begin
						cnt_nxt = '0;
						emit_n  = EMIT_W'(4);
						emit[0] = '{byte_out: {5'b11110, cp[20:18]}, is_end: 1'b0};
						emit[1] = '{byte_out: {2'b10, cp[17:12]}, is_end: 1'b0};
						emit[2] = '{byte_out: {2'b10, cp[11:6]}, is_end: 1'b0};
						emit[3] = '{byte_out: {2'b10, cp[5:0]}, is_end: 1'b0};
					end else begin
						single_f = 1'b1;
					end
				end
			endcase
		end
		if (single_f) begin
			if (b_n == 3'd1) begin
				cnt_nxt = '0;
				emit_n  = EMIT_W'(1);
				emit[0] = '{byte_out: b, is_end: 1'b0};
			end else if (b_n == 3'd0) begin
				cnt_nxt = '0;
			end else begin
				wr_en   = 1'b1;
				wr_idx  = '0;
				cnt_nxt = HOLD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
		end else if (proc) begin
			held_cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && wr_en) begin
			held_q[wr_idx] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(emit_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + (proc ? RES_CNT_W'(emit_n) : RES_CNT_W'(0))
				- (pop ? RES_CNT_W'(1) : RES_CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (EMIT_W'(i) < emit_n) begin
					fifo_q[wr_ptr_q + RES_PTR_W'(i)] <= emit[i];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= HOLD_CNT_W'(HOLD_DEPTH))
		else $error("lookahead overflow");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && req_s1.terminator |=> held_cnt_q == '0)
		else $error("terminator left held bytes");

	a_full_hold_drains: assert property (@(posedge clk) disable iff (!arst_n)
		proc && held_cnt_q == HOLD_CNT_W'(HOLD_DEPTH) |=> held_cnt_q <= HOLD_CNT_W'(1))
		else $error("full lookahead not resolved");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!proc && !pop |=> fifo_cnt_q == $past(fifo_cnt_q))
		else $error("queue count moved without push or pop");
`endif

endmodule

// File: verif/u8s_repair_check.sv
// Checker for the UTF-8 sanitizer: predicts cleaned bytes per request and compares results.
module u8s_repair_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  u8s_pkg::u8s_req_t req,
	input  logic              res_valid,
	input  logic              res_ready,
	input  u8s_pkg::u8s_res_t res,
	output int                fail_count,
	output int                pending_count
);
	import u8s_pkg::*;

	logic [7:0] look_bytes [HOLD_DEPTH];
	int         look_cnt = 0;
	logic [7:0] win [HOLD_DEPTH + 1];
	int         win_cnt;
	int         step_made;
	u8s_res_t   clean_q [$];

	function automatic int lead_len(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic bit cont_ok(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic void win_drop(input int k);
		int i;
		if (k > win_cnt)
			k = win_cnt;
		for (i = 0; i < win_cnt - k; i++)
			win[i] = win[i + k];
		win_cnt -= k;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		u8s_res_t e;
		e.byte_out = b;
		e.is_end = 1'b0;
		if (step_made < MAX_RES) begin
			clean_q.push_back(e);
			step_made++;
		end
	endfunction

	task automatic predict_clean_bytes(input u8s_req_t r);
		int          n;
		int          avail;
		int          i;
		bit          bad;
		bit          fail;
		int unsigned hi;
		int unsigned lo;
		int unsigned cp;
		u8s_res_t    e;
		if (r.terminator) begin
			look_cnt = 0;
			e.byte_out = 8'h00;
			e.is_end = 1'b1;
			clean_q.push_back(e);
			return;
		end
		for (i = 0; i < look_cnt; i++)
			win[i] = look_bytes[i];
		win_cnt = look_cnt;
		win[win_cnt] = r.byte_in;
		win_cnt++;
		step_made = 0;
		while (win_cnt > 0) begin
			n = lead_len(win[0]);
			if (n == 0) begin
				win_drop(1);
				continue;
			end
			avail = (win_cnt < n) ? win_cnt : n;
			bad = 1'b0;
			for (i = 1; i < avail; i++)
				if (!cont_ok(win[i]))
					bad = 1'b1;
			if (bad) begin
				win_drop(1);
				continue;
			end
			if (win_cnt < n)
				break;
			if (n == 3 && win[0] == SUR_LEAD && win[1] >= 8'hA0) begin
				// low surrogate with no high one in front
				if (win[1][7:4] == SUR_LO_NIB) begin
					win_drop(3);
					continue;
				end
				fail = (win_cnt > 3 && win[3] != SUR_LEAD) ||
					(win_cnt > 4 && win[4][7:4] != SUR_LO_NIB) ||
					(win_cnt > 5 && !cont_ok(win[5]));
				if (fail) begin
					win_drop(3);
					continue;
				end
				if (win_cnt < 6)
					break;
				hi = {16'h0, 4'hD, win[1][5:0], win[2][5:0]};
				lo = {16'h0, 4'hD, win[4][5:0], win[5][5:0]};
				cp = SUPP_BASE + ((hi - 32'hD800) << 10) + (lo - 32'hDC00);
				emit_byte({5'b11110, cp[20:18]});
				emit_byte({2'b10, cp[17:12]});
				emit_byte({2'b10, cp[11:6]});
				emit_byte({2'b10, cp[5:0]});
				win_drop(6);
				continue;
			end
			for (i = 0; i < n; i++)
				emit_byte(win[i]);
			win_drop(n);
		end
		look_cnt = (win_cnt > HOLD_DEPTH) ? HOLD_DEPTH : win_cnt;
		for (i = 0; i < look_cnt; i++)
			look_bytes[i] = win[i];
	endtask

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk) begin : watch
		u8s_res_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_clean_bytes(req);
			if (res_valid && res_ready) begin
				if (clean_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result byte %02h end %0b",
						res.byte_out, res.is_end));
				end else begin
					want = clean_q.pop_front();
					if (res.byte_out !== want.byte_out)
						flag_mismatch($sformatf("byte_out %02h, expected %02h",
							res.byte_out, want.byte_out));
					if (res.is_end !== want.is_end)
						flag_mismatch($sformatf("is_end %0b, expected %0b",
							res.is_end, want.is_end));
				end
			end
			pending_count = clean_q.size();
		end else begin
			fail_count = 0;
			pending_count = 0;
		end
	end

endmodule

// File: verif/tb.sv
// Testbench top for the UTF-8 sanitizer: clock, reset, request stimulus and verdict.
module tb;
	import u8s_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_ITEMS = 185;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     res_ready = 1'b0;
	u8s_req_t req = '0;
	logic     req_ready;
	logic     res_valid;
	u8s_res_t res;
	int       fail_count;
	int       pending_count;

	u8s_req_t text_q [$];
	int       burst_left = 0;
	int       idle_cycles = 0;
	int       rx_cyc = 0;

	utf8_sanitize_cesu8_repair u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	u8s_repair_check u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall modes rotate: always ready, random, fixed pattern, long stalls
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		case ((rx_cyc / 97) % 4)
			0:       res_ready <= 1'b1;
			1:       res_ready <= $urandom_range(0, 9) < 7;
			2:       res_ready <= (rx_cyc % 9) < 5;
			default: res_ready <= (rx_cyc % 40) >= 25;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("utf8_sanitize_cesu8_repair regression: fail");
					$finish;
				end
			end
		end
	end

	function automatic void push_text(input logic [7:0] b, input logic term);
		u8s_req_t r;
		r.byte_in = b;
		r.terminator = term;
		text_q.push_back(r);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	function automatic void queue_piece();
		int pick;
		int k;
		int extra;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			push_text(8'($urandom_range(0, 127)), 1'b0);
		end else if (pick < 32) begin
			push_text(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
			push_text(cont_byte(), 1'b0);
		end else if (pick < 44) begin
			push_text(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
			push_text(cont_byte(), 1'b0);
			push_text(cont_byte(), 1'b0);
		end else if (pick < 54) begin
			push_text(8'($urandom_range(8'hF0, 8'hF7)), 1'b0);
			for (k = 0; k < 3; k++)
				push_text(cont_byte(), 1'b0);
		end else if (pick < 70) begin
			push_text(SUR_LEAD, 1'b0);
			push_text(8'($urandom_range(8'hA0, 8'hAF)), 1'b0);
			push_text(cont_byte(), 1'b0);
			push_text(SUR_LEAD, 1'b0);
			push_text(8'($urandom_range(8'hB0, 8'hBF)), 1'b0);
			push_text(cont_byte(), 1'b0);
		end else if (pick < 76) begin
			push_text(SUR_LEAD, 1'b0);
			push_text(8'($urandom_range(8'hA0, 8'hAF)), 1'b0);
			push_text(cont_byte(), 1'b0);
		end else if (pick < 80) begin
			push_text(SUR_LEAD, 1'b0);
			push_text(8'($urandom_range(8'hB0, 8'hBF)), 1'b0);
			push_text(cont_byte(), 1'b0);
		end else if (pick < 86) begin
			// lead byte with a short or broken tail
			push_text(8'($urandom_range(8'hC0, 8'hF7)), 1'b0);
			extra = $urandom_range(0, 2);
			for (k = 0; k < extra; k++)
				push_text(cont_byte(), 1'b0);
			push_text(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 94) begin
			push_text(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			push_text(8'($urandom_range(0, 255)), 1'b1);
		end
	endfunction

	task automatic offer_req(input u8s_req_t r);
		int gap;
		bit rdy;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			rdy = req_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0);
		@(posedge clk);
	endtask

	initial begin : stim
		int half;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain bytes, each sequence length, a repaired pair, a lone high surrogate,
		// a broken sequence, orphans, then end of text
		push_text(8'h00, 1'b0); push_text(8'h7F, 1'b0);
		push_text(8'hC2, 1'b0); push_text(8'hA9, 1'b0);
		push_text(8'hE2, 1'b0); push_text(8'h82, 1'b0); push_text(8'hAC, 1'b0);
		push_text(8'hF0, 1'b0); push_text(8'h9F, 1'b0);
		push_text(8'h98, 1'b0); push_text(8'h80, 1'b0);
		push_text(8'hED, 1'b0); push_text(8'hA0, 1'b0); push_text(8'hBD, 1'b0);
		push_text(8'hED, 1'b0); push_text(8'hB8, 1'b0); push_text(8'h80, 1'b0);
		push_text(8'hED, 1'b0); push_text(8'hA0, 1'b0); push_text(8'h80, 1'b0);
		push_text(8'hC3, 1'b0); push_text(8'h41, 1'b0);
		push_text(8'h80, 1'b0); push_text(8'hFF, 1'b0);
		push_text(8'h5A, 1'b1);
		while (text_q.size() > 0)
			offer_req(text_q.pop_front());

		while (text_q.size() < RANDOM_ITEMS)
			queue_piece();
		push_text(8'($urandom_range(0, 255)), 1'b1);
		half = text_q.size() / 2;
		while (text_q.size() > half)
			offer_req(text_q.pop_front());
		drain_results();
		while (text_q.size() > 0)
			offer_req(text_q.pop_front());

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("utf8_sanitize_cesu8_repair regression: pass");
		else
			$display("utf8_sanitize_cesu8_repair regression: fail");
		$finish;
	end

endmodule
